// ===== sv/ffsa_pkg.sv =====
// ============================================================================
// ffsa_pkg: shared types and constants
// Item structures, status codes and table sizes of the section allocator.
// ============================================================================
package ffsa_pkg;

   // Table depth and offset width are fixed here because the item
   // structures carry handles and offsets at exactly these widths.
   localparam int SECT_COUNT        = 16;
   localparam int AlignBytesDefault = 64;

   localparam int SIZE_W = 25;
   localparam int IDX_W  = $clog2(SECT_COUNT);
   localparam int OFF_W  = 24;

   localparam logic [SIZE_W-1:0] MEM_SIZE_RESET = 25'd16777216;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NO_SPACE = 2'd1;
   localparam logic [1:0] ST_NO_SLOT  = 2'd2;
   localparam logic [1:0] ST_BAD_SECT = 2'd3;

   typedef struct packed {
      logic              operation;
      logic [SIZE_W-1:0] request_size;
      logic [IDX_W-1:0]  section_index;
   } req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [IDX_W-1:0] handle;
      logic [OFF_W-1:0] start_offset;
   } rsp_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic load;       // capture the item, clear the scan index
      logic scan_step;  // advance the free-slot scan
      logic walk_init;  // start the list walk at the head
      logic walk_step;  // advance the list walk
      logic commit;     // apply the decided update and emit a result
   } ffsa_cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic scan_done;  // free slot found or table exhausted
      logic walk_done;  // decision reached in the list walk
   } ffsa_stat_type;

endpackage

// ===== sv/ffsa_ctrl.sv =====
// ============================================================================
// ffsa_ctrl: allocator sequencer
// Steps one item through slot scan, list walk and commit.
// ============================================================================
module ffsa_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   output ffsa_pkg::ffsa_cmd_type cmd,
   input  ffsa_pkg::ffsa_stat_type stat
);
   import ffsa_pkg::*;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_WALK   = 2'd2;
   localparam logic [1:0] S_COMMIT = 2'd3;

   logic [1:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (stat.scan_done) begin
               cmd.walk_init = 1'b1;
               state_in      = S_WALK;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         S_WALK: begin
            if (stat.walk_done) begin
               state_in = S_COMMIT;
            end else begin
               cmd.walk_step = 1'b1;
            end
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   a_commit_once: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> !cmd.commit)
      else $error("commit repeated");
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !busy)
      else $error("load while busy");
   a_walk_follows: assert property (@(posedge clock) disable iff (reset)
      cmd.walk_init |=> (state_ff == S_WALK))
      else $error("walk not entered");

endmodule

// ===== sv/ffsa_datapath.sv =====
// ============================================================================
// ffsa_datapath: section table and decision logic
// Holds the section table, scans for a free slot and walks the sorted list.
// ============================================================================
module ffsa_datapath #(
   parameter int ALIGN_BYTES = ffsa_pkg::AlignBytesDefault
) (
   input  logic                        clock,
   input  logic                        reset,
   input  ffsa_pkg::req_type           req_item,
   input  logic [ffsa_pkg::SIZE_W-1:0] mem_size,
   input  ffsa_pkg::ffsa_cmd_type      cmd,
   output ffsa_pkg::ffsa_stat_type     stat,
   output logic                        rsp_valid,
   output ffsa_pkg::rsp_type           rsp_item
);
   import ffsa_pkg::*;

   localparam int SW  = $clog2(SECT_COUNT);
   localparam int LW  = SW + 1;                 // link with a none code
   localparam int AW  = 33;                     // wide enough for any sum
   localparam logic [LW-1:0] LINK_NONE = {LW{1'b1}};
   localparam logic [AW-1:0] ALIGN_W   = AW'(ALIGN_BYTES);
   // ALIGN_BYTES is a power of two, so the remainder is a mask.
   localparam logic [AW-1:0] ALIGN_MSK = AW'(ALIGN_BYTES - 1);
   localparam logic [AW-1:0] CAP_W     = AW'(64'd1 << OFF_W);

   // Section table. Starts are undefined until written.
   logic [OFF_W-1:0]       start_ff [SECT_COUNT];
   logic [SIZE_W-1:0]      len_ff   [SECT_COUNT];
   logic [LW-1:0]          link_ff  [SECT_COUNT];
   logic [LW-1:0]          head_ff;

   logic              op_ff;
   logic [AW-1:0]     size_ff;     // rounded request
   logic [IDX_W-1:0]  idx_ff;
   logic [SW:0]       scan_ff;     // free slot, SECT_COUNT when none
   logic              scan_done_ff;
   logic [LW-1:0]     cur_ff, prev_ff;
   logic [SW:0]       steps_ff;
   logic              done_ff;
   // Decision
   logic [1:0]        dst_ff;
   logic [AW-1:0]     dstart_ff;
   logic              wr_new_ff;   // write the new slot
   logic [LW-1:0]     new_link_ff;
   logic              wr_link_ff;  // relink section lnk_sel_ff
   logic [LW-1:0]     lnk_sel_ff, lnk_val_ff;
   logic              wr_head_ff;
   logic [LW-1:0]     head_val_ff;
   logic              clr_ff;      // free: clear length of idx

   logic rsp_valid_ff;
   rsp_type rsp_ff;

   function automatic logic [AW-1:0] align_up(input logic [AW-1:0] v);
      logic [AW-1:0] r;
      r = v & ALIGN_MSK;
      align_up = (r != '0) ? v - r + ALIGN_W : v;
   endfunction

   logic [AW-1:0] req_w, limit_w;
   assign req_w   = AW'(req_item.request_size);
   assign limit_w = (AW'(mem_size) > CAP_W) ? CAP_W : AW'(mem_size);

   logic          head_ok;
   logic [SW-1:0] head_i, cur_i, scan_i;
   logic [LW-1:0] nxt;
   logic          nxt_ok;
   logic [AW-1:0] cur_end, nxt_start, st_al;
   assign head_ok   = (head_ff != LINK_NONE) && (head_ff < LW'(SECT_COUNT));
   assign head_i    = head_ff[SW-1:0];
   assign cur_i     = cur_ff[SW-1:0];
   assign scan_i    = scan_ff[SW-1:0];
   assign nxt       = link_ff[cur_i];
   assign nxt_ok    = (nxt != LINK_NONE) && (nxt < LW'(SECT_COUNT));
   assign cur_end   = AW'(start_ff[cur_i]) + AW'(len_ff[cur_i]);
   assign nxt_start = AW'(start_ff[nxt[SW-1:0]]);
   assign st_al     = align_up(cur_end);

   assign stat.scan_done = scan_done_ff;
   assign stat.walk_done = done_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff        <= req_item.operation;
         size_ff      <= align_up((req_w == '0) ? ALIGN_W : req_w);
         idx_ff       <= req_item.section_index;
         scan_ff      <= '0;
         scan_done_ff <= 1'b0;
      end else if (cmd.scan_step) begin
         if (len_ff[scan_i] == '0) begin
            scan_done_ff <= 1'b1;
         end else if (scan_ff == (SW+1)'(SECT_COUNT - 1)) begin
            scan_ff      <= (SW+1)'(SECT_COUNT);
            scan_done_ff <= 1'b1;
         end else begin
            scan_ff <= scan_ff + 1'b1;
         end
      end

      if (cmd.walk_init) begin
         wr_new_ff <= 1'b0;
         wr_link_ff <= 1'b0;
         wr_head_ff <= 1'b0;
         clr_ff     <= 1'b0;
         dstart_ff  <= '0;
         dst_ff     <= ST_OK;
         steps_ff   <= '0;
         cur_ff     <= head_ff;
         prev_ff    <= head_ff;
         done_ff    <= 1'b1;
         if (op_ff == OP_ALLOC) begin
            if (!head_ok) begin
               if (size_ff > limit_w) begin
                  dst_ff <= ST_NO_SPACE;
               end else begin
                  wr_new_ff   <= 1'b1;
                  scan_ff     <= '0;
                  new_link_ff <= LINK_NONE;
                  wr_head_ff  <= 1'b1;
                  head_val_ff <= '0;
               end
            end else if (scan_ff[SW]) begin
               dst_ff <= ST_NO_SLOT;
            end else if (AW'(start_ff[head_i]) >= size_ff) begin
               wr_new_ff   <= 1'b1;
               new_link_ff <= head_ff;
               wr_head_ff  <= 1'b1;
               head_val_ff <= LW'(scan_ff);
            end else begin
               done_ff <= 1'b0;
            end
         end else begin
            if (!head_ok || ({1'b0, idx_ff} >= (IDX_W+1)'(SECT_COUNT))) begin
               dst_ff <= ST_BAD_SECT;
            end else if (head_ff == LW'(idx_ff)) begin
               clr_ff      <= 1'b1;
               wr_head_ff  <= 1'b1;
               head_val_ff <= link_ff[head_i];
            end else begin
               cur_ff  <= link_ff[head_i];
               done_ff <= 1'b0;
            end
         end
      end else if (cmd.walk_step) begin
         steps_ff <= steps_ff + 1'b1;
         if (op_ff == OP_ALLOC) begin
            if (steps_ff == (SW+1)'(SECT_COUNT)) begin
               dst_ff  <= ST_NO_SPACE;
               done_ff <= 1'b1;
            end else if (!nxt_ok) begin
               done_ff <= 1'b1;
               if (st_al > limit_w || (limit_w - st_al) < size_ff) begin
                  dst_ff <= ST_NO_SPACE;
               end else begin
                  dstart_ff   <= st_al;
                  wr_new_ff   <= 1'b1;
                  new_link_ff <= LINK_NONE;
                  wr_link_ff  <= 1'b1;
                  lnk_sel_ff  <= cur_ff;
                  lnk_val_ff  <= LW'(scan_ff);
               end
            end else if (nxt_start > cur_end && (nxt_start - cur_end) > size_ff) begin
               done_ff     <= 1'b1;
               dstart_ff   <= cur_end;
               wr_new_ff   <= 1'b1;
               new_link_ff <= nxt;
               wr_link_ff  <= 1'b1;
               lnk_sel_ff  <= cur_ff;
               lnk_val_ff  <= LW'(scan_ff);
            end else begin
               cur_ff <= nxt;
            end
         end else begin
            if (steps_ff == (SW+1)'(SECT_COUNT) ||
                !((cur_ff != LINK_NONE) && (cur_ff < LW'(SECT_COUNT)))) begin
               dst_ff  <= ST_BAD_SECT;
               done_ff <= 1'b1;
            end else if (cur_ff == LW'(idx_ff)) begin
               done_ff    <= 1'b1;
               clr_ff     <= 1'b1;
               wr_link_ff <= 1'b1;
               lnk_sel_ff <= prev_ff;
               lnk_val_ff <= link_ff[cur_i];
            end else begin
               prev_ff <= cur_ff;
               cur_ff  <= link_ff[cur_i];
            end
         end
      end

      if (cmd.commit) begin
         if (wr_new_ff) begin
            start_ff[scan_i] <= dstart_ff[OFF_W-1:0];
         end
      end
   end

   // Length, link and head carry reset values.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < SECT_COUNT; k++) begin
            len_ff[k]  <= '0;
            link_ff[k] <= LINK_NONE;
         end
         head_ff      <= LINK_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.commit;
         if (cmd.commit) begin
            if (wr_new_ff) begin
               len_ff[scan_i]  <= size_ff[SIZE_W-1:0];
               link_ff[scan_i] <= new_link_ff;
            end
            if (wr_link_ff) begin
               link_ff[lnk_sel_ff[SW-1:0]] <= lnk_val_ff;
            end
            if (clr_ff) begin
               len_ff[idx_ff[SW-1:0]] <= '0;
            end
            if (wr_head_ff) begin
               head_ff <= head_val_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_ff.status       <= dst_ff;
         rsp_ff.handle       <= (dst_ff == ST_OK && op_ff == OP_ALLOC) ?
                                IDX_W'(scan_ff) : '0;
         rsp_ff.start_offset <= (dst_ff == ST_OK && op_ff == OP_ALLOC) ?
                                OFF_W'(dstart_ff) : '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   a_rsp_after_commit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(cmd.commit))
      else $error("result without commit");
   a_ok_alloc_has_slot: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && op_ff == OP_ALLOC && dst_ff == ST_OK) |-> wr_new_ff)
      else $error("ok allocate writes no slot");
   a_free_clear: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && op_ff == OP_FREE && dst_ff == ST_OK) |-> clr_ff)
      else $error("ok free clears nothing");

endmodule

// ===== sv/first_fit_section_allocator_unit.sv =====
// ============================================================================
// first_fit_section_allocator_unit: first-fit section allocator
// Allocates and frees ALIGN_BYTES aligned sections (64 by default) from a sorted linked table.
// ============================================================================
// Sequence: an item is accepted, then the slot scan stops at the first unused
// entry, then the list walk visits one section a cycle, then the decision is
// committed and the registered result follows.
// One item is in flight at a time; busy is high from accept until the result,
// so no new item is taken before the last one is through. The next item can be
// accepted in the cycle that carries the result. The strobe lasts one cycle and
// cannot stall. Reset (synchronous) empties the list, marks every section unused
// and restores the memory size register to 16 MiB.
module first_fit_section_allocator_unit #(
   parameter int ALIGN_BYTES  = ffsa_pkg::AlignBytesDefault
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  ffsa_pkg::req_type           req_item,
   output logic                        rsp_valid,
   output ffsa_pkg::rsp_type           rsp_item,
   input  logic                        csr_write,
   input  logic [ffsa_pkg::SIZE_W-1:0] csr_wdata
);
   import ffsa_pkg::*;

   // The memory size register is the only configuration state.
   logic [SIZE_W-1:0] mem_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mem_size_ff <= MEM_SIZE_RESET;
      end else if (csr_write) begin
         mem_size_ff <= csr_wdata;
      end
   end

   ffsa_cmd_type  cmd;
   ffsa_stat_type stat;

   // The sequencer gates acceptance and steps the datapath.
   ffsa_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd),
      .stat  (stat)
   );

   // The datapath owns the table and produces the result item.
   ffsa_datapath #(
      .ALIGN_BYTES  (ALIGN_BYTES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .mem_size  (mem_size_ff),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   a_no_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result while busy");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accept did not raise busy");
   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("double result");

endmodule
